// ===== hdl/mer_pkg.sv =====
// ----------------------------------------------------------------------------
// mer_pkg
// shared widths, codes and controller/datapath bundles for the midpoint
// ellipse rasterizer
// ----------------------------------------------------------------------------
package mer_pkg;

    // field widths
    localparam int AXIS_BITS  = 10;
    localparam int COORD_BITS = 11;
    localparam int OUT_BITS   = COORD_BITS + 2;

    // internal widths
    localparam int X_BITS   = AXIS_BITS + 1;
    localparam int SQ_BITS  = 2 * AXIS_BITS;
    localparam int MUL_W    = 2 * AXIS_BITS + 3;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DEC_BITS = 4 * AXIS_BITS + 8;
    localparam int BIT_W    = $clog2(AXIS_BITS);

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // datapath operations
    typedef enum logic [3:0] {
        OP_IDLE     = 4'd0,
        OP_START    = 4'd1,
        OP_EMIT     = 4'd2,
        OP_UPD      = 4'd3,
        OP_XFER_SQ  = 4'd4,
        OP_XFER_MUL = 4'd5,
        OP_XFER_SUM = 4'd6,
        OP_SQ       = 4'd7,
        OP_PRE1     = 4'd8,
        OP_PRE2     = 4'd9,
        OP_PRE3     = 4'd10,
        OP_PRE4     = 4'd11,
        OP_TRY      = 4'd12,
        OP_MULT     = 4'd13,
        OP_CMP      = 4'd14
    } t_op;

    // command from controller to datapath
    typedef struct packed {
        t_op op;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic active;
        logic y_zero;
        logic axis_zero;
        logic to_region_two;
        logic search_last;
        logic out_busy;
    } t_stat;

endpackage

// ===== hdl/mer_if.sv =====
// ----------------------------------------------------------------------------
// mer_in_if / mer_out_if
// valid/ready channels carrying rasterizer commands and point sets
// ----------------------------------------------------------------------------
interface mer_in_if;
    import mer_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  kind;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [AXIS_BITS-1:0]  semi_axis_x;
    logic [AXIS_BITS-1:0]  semi_axis_y;

    modport source (
        output valid, kind, center_x, center_y, semi_axis_x, semi_axis_y,
        input  ready
    );

    modport sink (
        input  valid, kind, center_x, center_y, semi_axis_x, semi_axis_y,
        output ready
    );
endinterface

interface mer_out_if;
    import mer_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] pt0_x;
    logic signed [OUT_BITS-1:0] pt0_y;
    logic signed [OUT_BITS-1:0] pt1_x;
    logic signed [OUT_BITS-1:0] pt1_y;
    logic signed [OUT_BITS-1:0] pt2_x;
    logic signed [OUT_BITS-1:0] pt2_y;
    logic signed [OUT_BITS-1:0] pt3_x;
    logic signed [OUT_BITS-1:0] pt3_y;
    logic                       last;

    modport source (
        output valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, last,
        input  ready
    );

    modport sink (
        input  valid, pt0_x, pt0_y, pt1_x, pt1_y, pt2_x, pt2_y, pt3_x, pt3_y, last,
        output ready
    );
endinterface

// ===== hdl/midpoint_ellipse_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_top
// two-region midpoint ellipse generator emitting four mirrored points per step
// ----------------------------------------------------------------------------
// A start transaction (kind 0) loads the centre and semi-axes and emits
// nothing; it then occupies the block while a^2, b^2, 4a^4 and the start
// decision value are formed and the region switch column is found one bit
// at a time (square, multiply by a^2+b^2, compare) on the two shared
// multipliers. A zero semi-axis leaves the block idle. Each step
// transaction (kind 1) while an ellipse is active emits one point set into
// the output register, forms the two decision products and then applies
// them. The single step that crosses into region two goes on to rebuild
// the decision value (square, multiply, sum). The set with y = 0 carries
// last, needs no update and ends the ellipse; steps while idle are dropped.
// A new transaction is taken once the sequencer is idle and the output
// register is free or being read.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mer_in_if.sink    i_in,
    mer_out_if.source o_out
);
    import mer_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .i_stat     (w_stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (w_cmd)
    );

    // arithmetic and output register
    mer_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_center_x    (i_in.center_x),
        .i_center_y    (i_in.center_y),
        .i_semi_axis_x (i_in.semi_axis_x),
        .i_semi_axis_y (i_in.semi_axis_y),
        .i_out_ready   (o_out.ready),
        .o_stat        (w_stat),
        .o_out_valid   (o_out.valid),
        .o_pt0_x       (o_out.pt0_x),
        .o_pt0_y       (o_out.pt0_y),
        .o_pt1_x       (o_out.pt1_x),
        .o_pt1_y       (o_out.pt1_y),
        .o_pt2_x       (o_out.pt2_x),
        .o_pt2_y       (o_out.pt2_y),
        .o_pt3_x       (o_out.pt3_x),
        .o_pt3_y       (o_out.pt3_y),
        .o_last        (o_out.last)
    );

endmodule

// ===== hdl/mer_ctrl.sv =====
// ----------------------------------------------------------------------------
// mer_ctrl
// sequencer: accepts transactions and steps the datapath through the
// setup, switch-point search, step update and region change sequences
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_kind,
    input  mer_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output mer_pkg::t_cmd  o_cmd
);
    import mer_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_UPD  = 13'b0000000000010,
        S_T1   = 13'b0000000000100,
        S_T2   = 13'b0000000001000,
        S_T3   = 13'b0000000010000,
        S_SQ   = 13'b0000000100000,
        S_PRE1 = 13'b0000001000000,
        S_PRE2 = 13'b0000010000000,
        S_PRE3 = 13'b0000100000000,
        S_PRE4 = 13'b0001000000000,
        S_TRY  = 13'b0010000000000,
        S_MULT = 13'b0100000000000,
        S_CMP  = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_IDLE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_stat.out_busy;
                if (i_in_valid && !i_stat.out_busy) begin
                    if (i_kind == KIND_START) begin
                        o_cmd.op = OP_START;
                        if (!i_stat.axis_zero) begin
                            n_state = S_SQ;
                        end
                    end else if (i_stat.active) begin
                        o_cmd.op = OP_EMIT;
                        if (!i_stat.y_zero) begin
                            n_state = S_UPD;
                        end
                    end
                end
            end
            S_UPD: begin
                o_cmd.op = OP_UPD;
                n_state  = i_stat.to_region_two ? S_T1 : S_IDLE;
            end
            S_T1: begin
                o_cmd.op = OP_XFER_SQ;
                n_state  = S_T2;
            end
            S_T2: begin
                o_cmd.op = OP_XFER_MUL;
                n_state  = S_T3;
            end
            S_T3: begin
                o_cmd.op = OP_XFER_SUM;
                n_state  = S_IDLE;
            end
            S_SQ: begin
                o_cmd.op = OP_SQ;
                n_state  = S_PRE1;
            end
            S_PRE1: begin
                o_cmd.op = OP_PRE1;
                n_state  = S_PRE2;
            end
            S_PRE2: begin
                o_cmd.op = OP_PRE2;
                n_state  = S_PRE3;
            end
            S_PRE3: begin
                o_cmd.op = OP_PRE3;
                n_state  = S_PRE4;
            end
            S_PRE4: begin
                o_cmd.op = OP_PRE4;
                n_state  = S_TRY;
            end
            S_TRY: begin
                o_cmd.op = OP_TRY;
                n_state  = S_MULT;
            end
            S_MULT: begin
                o_cmd.op = OP_MULT;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = OP_CMP;
                n_state  = i_stat.search_last ? S_IDLE : S_TRY;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hdl/mer_datapath.sv =====
// ----------------------------------------------------------------------------
// mer_datapath
// ellipse state, two registered multipliers, decision arithmetic, the
// bit-by-bit switch-point search and the output register
// ----------------------------------------------------------------------------
module mer_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mer_pkg::t_cmd                       i_cmd,
    input  logic [mer_pkg::COORD_BITS-1:0]      i_center_x,
    input  logic [mer_pkg::COORD_BITS-1:0]      i_center_y,
    input  logic [mer_pkg::AXIS_BITS-1:0]       i_semi_axis_x,
    input  logic [mer_pkg::AXIS_BITS-1:0]       i_semi_axis_y,
    input  logic                                i_out_ready,
    output mer_pkg::t_stat                      o_stat,
    output logic                                o_out_valid,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_pt0_x,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_pt0_y,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_pt1_x,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_pt1_y,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_pt2_x,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_pt2_y,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_pt3_x,
    output logic signed [mer_pkg::OUT_BITS-1:0] o_pt3_y,
    output logic                                o_last
);
    import mer_pkg::*;

    typedef logic signed [MUL_W-1:0]    t_mop;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [DEC_BITS-1:0] t_dec;

    // ellipse state
    logic [COORD_BITS-1:0] r_ctr_col;
    logic [COORD_BITS-1:0] r_ctr_row;
    logic [AXIS_BITS-1:0]  r_a;
    logic [AXIS_BITS-1:0]  r_b;
    logic [SQ_BITS-1:0]    r_a_sq;
    logic [SQ_BITS-1:0]    r_b_sq;
    logic [SQ_BITS:0]      r_sum_sq;
    logic [X_BITS-1:0]     r_x;
    logic [AXIS_BITS-1:0]  r_y;
    logic [AXIS_BITS-1:0]  r_sw;
    logic [BIT_W-1:0]      r_bit;
    logic                  r_cand_le;
    t_dec                  r_d;
    t_dec                  r_kq;
    t_dec                  r_four_a4;
    t_dec                  r_pa;
    t_dec                  r_pb;
    logic                  r_reg2;
    logic                  r_active;

    // output register
    logic                       r_out_valid;
    logic signed [OUT_BITS-1:0] r_col_p;
    logic signed [OUT_BITS-1:0] r_col_m;
    logic signed [OUT_BITS-1:0] r_row_p;
    logic signed [OUT_BITS-1:0] r_row_m;
    logic                       r_last;

    // combinational helpers
    t_mop                 w_ma1;
    t_mop                 w_mb1;
    t_mop                 w_ma2;
    t_mop                 w_mb2;
    t_mop                 w_t;
    t_prod                w_prod1;
    t_prod                w_prod2;
    t_dec                 n_pa;
    t_dec                 n_pb;
    logic [AXIS_BITS-1:0] w_cand;
    logic [X_BITS-1:0]    w_x_inc;
    logic                 w_neg;
    logic                 w_to_r2;
    logic                 w_y_zero;

    assign w_cand   = r_sw | (AXIS_BITS'(1) << r_bit);
    assign w_t      = (t_mop'(w_cand) <<< 1) - t_mop'(1);
    assign w_x_inc  = r_x + X_BITS'(1);
    assign w_neg    = r_d[DEC_BITS-1];
    assign w_to_r2  = !r_reg2 && (w_x_inc > X_BITS'(r_sw));
    assign w_y_zero = (r_y == '0);

    // multiplier operand selection
    always_comb begin
        w_ma1 = '0;
        w_mb1 = '0;
        w_ma2 = '0;
        w_mb2 = '0;
        unique case (i_cmd.op)
            OP_EMIT: begin
                // step increments b^2(2x+3) and a^2(2y-2) in region one, b^2(2x+2) and a^2(2y-3) in region two
                w_ma1 = t_mop'(r_b_sq);
                w_mb1 = (t_mop'(r_x) <<< 1) + (r_reg2 ? t_mop'(2) : t_mop'(3));
                w_ma2 = t_mop'(r_a_sq);
                w_mb2 = (t_mop'(r_y) <<< 1) - (r_reg2 ? t_mop'(3) : t_mop'(2));
            end
            OP_XFER_SQ: begin
                w_ma1 = t_mop'(r_x);
                w_mb1 = t_mop'(r_x) + t_mop'(1);
                w_ma2 = t_mop'(r_y) - t_mop'(1);
                w_mb2 = t_mop'(r_y) - t_mop'(1);
            end
            OP_XFER_MUL: begin
                w_ma1 = t_mop'(r_b_sq);
                w_mb1 = $signed(r_pa[MUL_W-1:0]);
                w_ma2 = t_mop'(r_a_sq);
                w_mb2 = $signed(r_pb[MUL_W-1:0]);
            end
            OP_SQ: begin
                w_ma1 = t_mop'(r_a);
                w_mb1 = t_mop'(r_a);
                w_ma2 = t_mop'(r_b);
                w_mb2 = t_mop'(r_b);
            end
            OP_PRE2: begin
                w_ma1 = t_mop'(r_a_sq);
                w_mb1 = t_mop'(r_a_sq);
                w_ma2 = t_mop'(r_a_sq);
                w_mb2 = t_mop'(r_b);
            end
            OP_PRE3: begin
                w_ma1 = t_mop'(r_a_sq);
                w_mb1 = t_mop'(r_b_sq);
            end
            OP_TRY: begin
                w_ma1 = w_t;
                w_mb1 = w_t;
            end
            OP_MULT: begin
                w_ma2 = $signed(r_pa[MUL_W-1:0]);
                w_mb2 = t_mop'(r_sum_sq);
            end
            default: begin
                w_ma1 = '0;
            end
        endcase
    end

    // the two multipliers, registered
    assign w_prod1 = w_ma1 * w_mb1;
    assign w_prod2 = w_ma2 * w_mb2;
    assign n_pa    = t_dec'(w_prod1);
    assign n_pb    = t_dec'(w_prod2);

    // arithmetic state, no reset needed
    always_ff @(posedge i_clk) begin
        r_pa <= n_pa;
        r_pb <= n_pb;
        unique case (i_cmd.op)
            OP_START: begin
                r_ctr_col <= i_center_x;
                r_ctr_row <= i_center_y;
                r_a       <= i_semi_axis_x;
                r_b       <= i_semi_axis_y;
                r_x       <= '0;
                r_y       <= i_semi_axis_y;
                r_sw      <= '0;
                r_bit     <= BIT_W'(AXIS_BITS - 1);
            end
            OP_EMIT: begin
                r_col_p <= OUT_BITS'(r_ctr_col) + OUT_BITS'(r_x);
                r_col_m <= OUT_BITS'(r_ctr_col) - OUT_BITS'(r_x);
                r_row_p <= OUT_BITS'(r_ctr_row) + OUT_BITS'(r_y);
                r_row_m <= OUT_BITS'(r_ctr_row) - OUT_BITS'(r_y);
                r_last  <= w_y_zero;
            end
            OP_UPD: begin
                if (!r_reg2) begin
                    // region one: x always advances
                    if (w_neg) begin
                        r_d <= r_d + r_pa;
                    end else begin
                        r_d <= r_d + r_pa - r_pb;
                        r_y <= r_y - AXIS_BITS'(1);
                    end
                    r_x <= w_x_inc;
                end else begin
                    // region two: y always retreats
                    if (w_neg) begin
                        r_d <= r_d + r_pa - r_pb;
                        r_x <= w_x_inc;
                    end else begin
                        r_d <= r_d - r_pb;
                    end
                    r_y <= r_y - AXIS_BITS'(1);
                end
            end
            OP_XFER_SUM: begin
                // b^2(x^2+x) + a^2(y-1)^2 + floor(b^2/4) - a^2 b^2
                r_d <= r_pa + r_pb + r_kq;
            end
            OP_PRE1: begin
                r_a_sq   <= r_pa[SQ_BITS-1:0];
                r_b_sq   <= r_pb[SQ_BITS-1:0];
                r_sum_sq <= r_pa[SQ_BITS:0] + r_pb[SQ_BITS:0];
            end
            OP_PRE3: begin
                r_four_a4 <= r_pa <<< 2;
                r_d       <= t_dec'(r_a_sq >> 2) + t_dec'(r_b_sq) - r_pb;
            end
            OP_PRE4: begin
                r_kq <= t_dec'(r_b_sq >> 2) - r_pa;
            end
            OP_TRY: begin
                r_cand_le <= (w_cand <= r_a);
            end
            OP_CMP: begin
                // keep the candidate bit if n <= a and (2n-1)^2 (a^2+b^2) <= 4a^4
                if (r_cand_le && (r_pb <= r_four_a4)) begin
                    r_sw <= w_cand;
                end
                r_bit <= r_bit - BIT_W'(1);
            end
            default: begin
                r_cand_le <= r_cand_le;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_reg2      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == OP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_START: begin
                    r_active <= 1'b0;
                    r_reg2   <= 1'b0;
                end
                OP_EMIT: begin
                    if (w_y_zero) begin
                        r_active <= 1'b0;
                    end
                end
                OP_UPD: begin
                    if (w_to_r2) begin
                        r_reg2 <= 1'b1;
                    end
                end
                OP_CMP: begin
                    if (r_bit == '0) begin
                        r_active <= 1'b1;
                    end
                end
                default: begin
                    r_active <= r_active;
                end
            endcase
        end
    end

    // status to the controller
    assign o_stat.active        = r_active;
    assign o_stat.y_zero        = w_y_zero;
    assign o_stat.axis_zero     = (i_semi_axis_x == '0) || (i_semi_axis_y == '0);
    assign o_stat.to_region_two = w_to_r2;
    assign o_stat.search_last   = (r_bit == '0);
    assign o_stat.out_busy      = r_out_valid && !i_out_ready;

    // output mapping of the mirrored points
    assign o_out_valid = r_out_valid;
    assign o_pt0_x     = r_col_p;
    assign o_pt0_y     = r_row_p;
    assign o_pt1_x     = r_col_m;
    assign o_pt1_y     = r_row_p;
    assign o_pt2_x     = r_col_p;
    assign o_pt2_y     = r_row_m;
    assign o_pt3_x     = r_col_m;
    assign o_pt3_y     = r_row_m;
    assign o_last      = r_last;

endmodule

// ===== hdl/mer_checker.sv =====
// ----------------------------------------------------------------------------
// mer_checker
// port-level checks on the rasterizer, attached to the top level by bind
// ----------------------------------------------------------------------------
module mer_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_in_kind,
    input logic [mer_pkg::AXIS_BITS-1:0]       i_in_semi_axis_x,
    input logic [mer_pkg::AXIS_BITS-1:0]       i_in_semi_axis_y,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [mer_pkg::OUT_BITS-1:0] i_pt0_x,
    input logic signed [mer_pkg::OUT_BITS-1:0] i_pt0_y,
    input logic signed [mer_pkg::OUT_BITS-1:0] i_pt1_x,
    input logic signed [mer_pkg::OUT_BITS-1:0] i_pt1_y,
    input logic signed [mer_pkg::OUT_BITS-1:0] i_pt2_x,
    input logic signed [mer_pkg::OUT_BITS-1:0] i_pt2_y,
    input logic signed [mer_pkg::OUT_BITS-1:0] i_pt3_x,
    input logic signed [mer_pkg::OUT_BITS-1:0] i_pt3_y,
    input logic                                i_last
);
    import mer_pkg::*;

    // a stalled point set holds
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pt0_x)
            && $stable(i_pt0_y) && $stable(i_pt3_x) && $stable(i_pt3_y) && $stable(i_last))
        else $error("point set changed while stalled");

    // the four points mirror one another
    a_symmetry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_pt0_x == i_pt2_x) && (i_pt1_x == i_pt3_x)
            && (i_pt0_y == i_pt1_y) && (i_pt2_y == i_pt3_y))
        else $error("point set not symmetric");

    // last marks exactly the set on the horizontal axis
    a_last_axis : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_pt0_y == i_pt2_y)))
        else $error("last flag disagrees with y = 0");

    // a fresh point set only follows an accepted step transaction
    a_fresh_after_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !$past(i_out_valid && !i_out_ready)
            |-> $past(i_in_valid && i_in_ready && (i_in_kind == KIND_STEP)))
        else $error("point set without a step transaction");

    // a real start keeps the block busy for its setup
    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_kind == KIND_START)
            && (i_in_semi_axis_x != '0) && (i_in_semi_axis_y != '0) |=> !i_in_ready)
        else $error("ready during ellipse setup");

endmodule

bind midpoint_ellipse_rasterizer_top mer_checker u_mer_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_kind        (i_in.kind),
    .i_in_semi_axis_x (i_in.semi_axis_x),
    .i_in_semi_axis_y (i_in.semi_axis_y),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_pt0_x          (o_out.pt0_x),
    .i_pt0_y          (o_out.pt0_y),
    .i_pt1_x          (o_out.pt1_x),
    .i_pt1_y          (o_out.pt1_y),
    .i_pt2_x          (o_out.pt2_x),
    .i_pt2_y          (o_out.pt2_y),
    .i_pt3_x          (o_out.pt3_x),
    .i_pt3_y          (o_out.pt3_y),
    .i_last           (o_out.last)
);
